// ===== sv/sorted_set_list_defines.svh =====
// ---------------------------------------------------------------------------
// sorted_set_list assertion macros
// Immediate-cycle and next-cycle implication checks on clk, off in reset.
// ---------------------------------------------------------------------------
`ifndef SORTED_SET_LIST_DEFINES_SVH
`define SORTED_SET_LIST_DEFINES_SVH

// ante and cons hold in the same cycle
`define SSL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons holds in the cycle after ante
`define SSL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sset_pkg.sv =====
// ---------------------------------------------------------------------------
// sset_pkg
// Sizes, command and status codes and the value memory request type.
// ---------------------------------------------------------------------------
package sset_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;
    localparam int CMD_W = 3;
    localparam int ST_W  = 3;
    localparam int OCC_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_CLEAR  = 3'd2,
        CMD_SUCC   = 3'd3,
        CMD_PRED   = 3'd4
    } cmd_code_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_FULL     = 3'd3,
        ST_NONEIGH  = 3'd4
    } status_t;

    typedef struct packed {
        logic                    rd_en;
        logic [IDX_W-1:0]        rd_addr;
        logic                    wr_en;
        logic [IDX_W-1:0]        wr_addr;
        logic signed [VAL_W-1:0] wr_data;
    } mem_req_t;

endpackage

// ===== sv/sset_cmd_if.sv =====
// ---------------------------------------------------------------------------
// sset_cmd_if
// Command channel: one beat carries a command code and a value.
// ---------------------------------------------------------------------------
interface sset_cmd_if;

    logic                              valid;
    logic                              ready;
    logic [sset_pkg::CMD_W-1:0]        command;
    logic signed [sset_pkg::VAL_W-1:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);

endinterface

// ===== sv/sset_res_if.sv =====
// ---------------------------------------------------------------------------
// sset_res_if
// Result channel: status, neighbour and a summary of the set per beat.
// ---------------------------------------------------------------------------
interface sset_res_if;

    logic                              valid;
    logic                              ready;
    logic [sset_pkg::ST_W-1:0]         status;
    logic signed [sset_pkg::VAL_W-1:0] neighbour;
    logic signed [sset_pkg::VAL_W-1:0] smallest;
    logic signed [sset_pkg::VAL_W-1:0] largest;
    logic [sset_pkg::OCC_W-1:0]        occupancy;
    logic                              is_empty;

    modport source (
        output valid, output status, output neighbour, output smallest,
        output largest, output occupancy, output is_empty, input ready
    );
    modport sink (
        input valid, input status, input neighbour, input smallest,
        input largest, input occupancy, input is_empty, output ready
    );

endinterface

// ===== sv/sset_mem.sv =====
// ---------------------------------------------------------------------------
// sset_mem
// Value store: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module sset_mem (
    input  logic                              clk,
    input  sset_pkg::mem_req_t                req,
    output logic signed [sset_pkg::VAL_W-1:0] rd_data
);

    logic signed [sset_pkg::VAL_W-1:0] mem [sset_pkg::DEPTH];
    logic signed [sset_pkg::VAL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/sset_ctrl.sv =====
// ---------------------------------------------------------------------------
// sset_ctrl
// Sequencer: scans the store with one comparator, shifts entries through
// the memory's read and write ports, then gathers the result beat.
// ---------------------------------------------------------------------------
module sset_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    sset_cmd_if.sink                          cmd,
    sset_res_if.source                        res,
    output sset_pkg::mem_req_t                mem_req,
    input  logic signed [sset_pkg::VAL_W-1:0] mem_rd_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_CMP,
        S_DECIDE,
        S_INS_RD,
        S_INS_WR,
        S_REM_RD,
        S_REM_WR,
        S_NEIGH,
        S_MIN,
        S_MAX,
        S_DONE
    } state_t;

    localparam int IW = sset_pkg::IDX_W;
    localparam int CW = sset_pkg::CNT_W;
    localparam int VW = sset_pkg::VAL_W;

    state_t                       state_reg,     state_next;
    logic [sset_pkg::CMD_W-1:0]   cmd_reg,       cmd_next;
    logic signed [VW-1:0]         val_reg,       val_next;
    logic [CW-1:0]                i_reg,         i_next;
    logic [CW-1:0]                j_reg,         j_next;
    logic                         found_reg,     found_next;
    logic [CW-1:0]                count_reg,     count_next;
    sset_pkg::status_t            status_reg,    status_next;
    logic signed [VW-1:0]         neigh_reg,     neigh_next;
    logic signed [VW-1:0]         min_reg,       min_next;
    logic                         res_valid_reg, res_valid_next;
    sset_pkg::status_t            res_status_reg, res_status_next;
    logic signed [VW-1:0]         res_neigh_reg, res_neigh_next;
    logic signed [VW-1:0]         res_min_reg,   res_min_next;
    logic signed [VW-1:0]         res_max_reg,   res_max_next;
    logic [CW-1:0]                res_count_reg, res_count_next;

    logic          lt;
    logic          eq;
    logic [CW-1:0] i_inc;
    logic [CW-1:0] i_dec;
    logic [CW-1:0] j_inc;
    logic [CW-1:0] j_dec;
    logic [CW-1:0] count_dec;

    // the shared comparator
    assign lt = mem_rd_data < val_reg;
    assign eq = mem_rd_data == val_reg;

    assign i_inc     = i_reg + 1'b1;
    assign i_dec     = i_reg - 1'b1;
    assign j_inc     = j_reg + 1'b1;
    assign j_dec     = j_reg - 1'b1;
    assign count_dec = count_reg - 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        val_next        = val_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        found_next      = found_reg;
        count_next      = count_reg;
        status_next     = status_reg;
        neigh_next      = neigh_reg;
        min_next        = min_reg;
        res_valid_next  = res_valid_reg;
        res_status_next = res_status_reg;
        res_neigh_next  = res_neigh_reg;
        res_min_next    = res_min_reg;
        res_max_next    = res_max_reg;
        res_count_next  = res_count_reg;
        mem_req         = '0;

        if (res_valid_reg && res.ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    cmd_next    = cmd.command;
                    val_next    = cmd.value;
                    i_next      = '0;
                    status_next = sset_pkg::ST_OK;
                    neigh_next  = '0;
                    if (cmd.command == sset_pkg::CMD_CLEAR)
                    begin
                        count_next = '0;
                        state_next = S_MIN;
                    end
                    else if (cmd.command inside {sset_pkg::CMD_INSERT, sset_pkg::CMD_REMOVE,
                                                 sset_pkg::CMD_SUCC, sset_pkg::CMD_PRED})
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_MIN;
                    end
                end
            end
            S_SCAN:
            begin
                if (i_reg == count_reg)
                begin
                    found_next = 1'b0;
                    state_next = S_DECIDE;
                end
                else
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = i_reg[IW-1:0];
                    state_next      = S_CMP;
                end
            end
            S_CMP:
            begin
                if (lt)
                begin
                    i_next     = i_inc;
                    state_next = S_SCAN;
                end
                else
                begin
                    found_next = eq;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_MIN;
                case (cmd_reg)
                    sset_pkg::CMD_INSERT:
                    begin
                        if (found_reg)
                        begin
                            status_next = sset_pkg::ST_DUP;
                        end
                        else if (count_reg == CW'(sset_pkg::DEPTH))
                        begin
                            status_next = sset_pkg::ST_FULL;
                        end
                        else
                        begin
                            j_next     = count_reg;
                            state_next = S_INS_RD;
                        end
                    end
                    sset_pkg::CMD_REMOVE:
                    begin
                        if (!found_reg)
                        begin
                            status_next = sset_pkg::ST_NOTFOUND;
                        end
                        else
                        begin
                            j_next     = i_reg;
                            state_next = S_REM_RD;
                        end
                    end
                    sset_pkg::CMD_SUCC:
                    begin
                        if (!found_reg)
                        begin
                            status_next = sset_pkg::ST_NOTFOUND;
                        end
                        else if (i_inc >= count_reg)
                        begin
                            status_next = sset_pkg::ST_NONEIGH;
                        end
                        else
                        begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = i_inc[IW-1:0];
                            state_next      = S_NEIGH;
                        end
                    end
                    sset_pkg::CMD_PRED:
                    begin
                        if (!found_reg)
                        begin
                            status_next = sset_pkg::ST_NOTFOUND;
                        end
                        else if (i_reg == '0)
                        begin
                            status_next = sset_pkg::ST_NONEIGH;
                        end
                        else
                        begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = i_dec[IW-1:0];
                            state_next      = S_NEIGH;
                        end
                    end
                    default:
                    begin
                        state_next = S_MIN;
                    end
                endcase
            end
            S_INS_RD:
            begin
                if (j_reg == i_reg)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = i_reg[IW-1:0];
                    mem_req.wr_data = val_reg;
                    count_next      = count_reg + 1'b1;
                    state_next      = S_MIN;
                end
                else
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = j_dec[IW-1:0];
                    state_next      = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = j_reg[IW-1:0];
                mem_req.wr_data = mem_rd_data;
                j_next          = j_dec;
                state_next      = S_INS_RD;
            end
            S_REM_RD:
            begin
                if (j_inc >= count_reg)
                begin
                    count_next = count_dec;
                    state_next = S_MIN;
                end
                else
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = j_inc[IW-1:0];
                    state_next      = S_REM_WR;
                end
            end
            S_REM_WR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = j_reg[IW-1:0];
                mem_req.wr_data = mem_rd_data;
                j_next          = j_inc;
                state_next      = S_REM_RD;
            end
            S_NEIGH:
            begin
                neigh_next = mem_rd_data;
                state_next = S_MIN;
            end
            S_MIN:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = '0;
                state_next      = S_MAX;
            end
            S_MAX:
            begin
                min_next        = (count_reg != '0) ? mem_rd_data : '0;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = (count_reg != '0) ? count_dec[IW-1:0] : '0;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                // wait for the output register to free up
                if (!res_valid_reg || res.ready)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = status_reg;
                    res_neigh_next  = neigh_reg;
                    res_min_next    = min_reg;
                    res_max_next    = (count_reg != '0) ? mem_rd_data : '0;
                    res_count_next  = count_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= '0;
            val_reg        <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            found_reg      <= 1'b0;
            count_reg      <= '0;
            status_reg     <= sset_pkg::ST_OK;
            neigh_reg      <= '0;
            min_reg        <= '0;
            res_valid_reg  <= 1'b0;
            res_status_reg <= sset_pkg::ST_OK;
            res_neigh_reg  <= '0;
            res_min_reg    <= '0;
            res_max_reg    <= '0;
            res_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            val_reg        <= val_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            found_reg      <= found_next;
            count_reg      <= count_next;
            status_reg     <= status_next;
            neigh_reg      <= neigh_next;
            min_reg        <= min_next;
            res_valid_reg  <= res_valid_next;
            res_status_reg <= res_status_next;
            res_neigh_reg  <= res_neigh_next;
            res_min_reg    <= res_min_next;
            res_max_reg    <= res_max_next;
            res_count_reg  <= res_count_next;
        end
    end

    assign cmd.ready     = (state_reg == S_IDLE);
    assign res.valid     = res_valid_reg;
    assign res.status    = res_status_reg;
    assign res.neighbour = res_neigh_reg;
    assign res.smallest  = res_min_reg;
    assign res.largest   = res_max_reg;
    assign res.occupancy = sset_pkg::OCC_W'(32'(res_count_reg));
    assign res.is_empty  = (res_count_reg == '0);

endmodule

// ===== sv/sorted_set_list.sv =====
// ---------------------------------------------------------------------------
// sorted_set_list
// Ordered set of distinct signed values with insert, remove, clear and
// successor / predecessor lookup; one result beat per command beat.
// ---------------------------------------------------------------------------
// The set lives in a single-port-read, single-port-write memory of DEPTH
// entries, and one comparator walks it from the smallest entry upwards;
// inserts and removes then move the entries above the position through the
// same ports, one read and one write per entry moved. Clear and the unused
// codes skip the walk. Every command ends by reading the smallest and the
// largest entry, and the result may wait for the output register; the
// command channel is not ready until the result has gone into the output
// register, which holds it while the next command is already taken. No
// clearing pass follows reset: stored values are only used below the
// current occupancy.
// ---------------------------------------------------------------------------
`include "sorted_set_list_defines.svh"

module sorted_set_list (
    input  logic       clk,
    input  logic       rst_n,
    sset_cmd_if.sink   cmd,
    sset_res_if.source res
);

    sset_pkg::mem_req_t                mem_req;
    logic signed [sset_pkg::VAL_W-1:0] mem_rd_data;

    sset_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .res         (res),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data)
    );

    sset_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    `SSL_ASSERT_NEXT(a_busy_after_beat, cmd.valid && cmd.ready, !cmd.ready, "ready after beat")
    `SSL_ASSERT_SAME(a_empty_summary, res.valid && res.is_empty, res.occupancy == '0 && res.smallest == '0 && res.largest == '0, "empty summary")
    `SSL_ASSERT_SAME(a_neigh_zero, res.valid && res.status != sset_pkg::ST_OK, res.neighbour == '0, "neighbour not zero")
    `SSL_ASSERT_SAME(a_min_max_order, res.valid && !res.is_empty, res.smallest <= res.largest, "smallest above largest")

endmodule
